FILE: hdl/utf8_glyph_quad_layout_macros.svh
// assertion macros for the utf8 glyph quad layout block
`ifndef UTF8_GLYPH_QUAD_LAYOUT_MACROS_SVH
`define UTF8_GLYPH_QUAD_LAYOUT_MACROS_SVH

// property checked on the rising clock edge, off while reset is low
`define UGQL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked on the rising clock edge at all times
`define UGQL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

FILE: hdl/ugql_pkg.sv
// shared types and constants for the utf8 glyph quad layout block
`timescale 1ns / 1ps
`default_nettype none

package ugql_pkg;

    localparam int GLYPH_ENTRIES_DEF   = 1024;
    localparam int QUAD_COUNT_BITS_DEF = 16;

    localparam int IN_DATA_BITS  = 88;
    localparam int OUT_DATA_BITS = 160;
    localparam int CFG_DATA_BITS = 15;

    typedef enum logic [1:0] {
        MODE_TEXT  = 2'd0,
        MODE_GLYPH = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    typedef enum logic [0:0] {
        REG_MAX_LINE_WIDTH = 1'b0,
        REG_LINE_HEIGHT    = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        OP_GLYPH   = 3'b001,
        OP_NEWLINE = 3'b010,
        OP_CLEAR   = 3'b100
    } op_t;

    localparam logic [7:0] BYTE_ASCII_MAX = 8'h7f;
    localparam logic [7:0] BYTE_NEWLINE   = 8'h0a;
    localparam logic [7:0] LEAD2_MIN      = 8'hc0;
    localparam logic [7:0] LEAD2_MAX      = 8'hdf;
    localparam logic [7:0] LEAD3_MIN      = 8'he0;
    localparam logic [7:0] LEAD3_MAX      = 8'hef;
    localparam logic [7:0] LEAD4_MIN      = 8'hf0;
    localparam logic [7:0] LEAD4_MAX      = 8'hf7;

    localparam logic [14:0] MAX_LINE_WIDTH_RST = 15'd0;
    localparam logic [7:0]  LINE_HEIGHT_RST    = 8'd16;

    typedef struct packed {
        logic [11:0] atlas_v;
        logic [11:0] atlas_u;
        logic [7:0]  advance;
        logic [7:0]  height;
        logic [7:0]  width;
        logic [7:0]  offset_y;
        logic [7:0]  offset_x;
    } glyph_entry_t;

    localparam int GLYPH_BITS = $bits(glyph_entry_t);

endpackage

`default_nettype wire

FILE: hdl/ugql_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module ugql_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/utf8_glyph_quad_layout.sv
// top level: utf8 decoder with glyph metric lookup and quad layout
// s_* channel carries one beat per text byte, glyph table write or restart;
// s_tuser selects the kind of beat, s_tdata carries the byte and glyph fields.
// m_* channel carries one beat per emitted glyph quad.
// cfg_we/cfg_addr/cfg_data write max_line_width (0) and line_height (1).
// a byte that completes a code point passes the glyph ram read, then the layout
// stage, whose result is registered into the output.
// throughput: one input beat per cycle unless stalled; the pen and quad counter
// are updated in the layout stage, so back-to-back glyphs see each other's advance.
// the glyph table lives in a ram with registered read; entries hold nothing
// until written. a glyph write takes effect for the very next beat.
// reset clears the decoder, pen, quad counter and pipeline valids and loads
// the register defaults; the glyph table keeps its contents.
// when the output beat stalls, beats are still taken until a glyph waits in the
// layout stage; after that s_tready falls until the output beat is taken.
`timescale 1ns / 1ps
`default_nettype none

module utf8_glyph_quad_layout #(
    parameter int GLYPH_ENTRIES   = ugql_pkg::GLYPH_ENTRIES_DEF,
    parameter int QUAD_COUNT_BITS = ugql_pkg::QUAD_COUNT_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // mode
    input  wire logic [1:0]                         s_tuser,
    // text_byte, glyph_slot, glyph_offset_x, glyph_offset_y, glyph_width,
    // glyph_height, glyph_advance, glyph_atlas_u, glyph_atlas_v, zero pad
    input  wire logic [ugql_pkg::IN_DATA_BITS-1:0]  s_tdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // quad_left, quad_bottom, quad_right, quad_top, tex_u_first, tex_v_first,
    // tex_u_second, tex_v_second, base_vertex, code_point, zero pad
    output logic [ugql_pkg::OUT_DATA_BITS-1:0]      m_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic                               cfg_we,
    input  wire logic [0:0]                         cfg_addr,
    input  wire logic [ugql_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    localparam int AW = $clog2(GLYPH_ENTRIES);
    localparam logic [20:0] ENTRIES_CP   = 21'(GLYPH_ENTRIES);
    localparam logic [16:0] ENTRIES_SLOT = 17'(GLYPH_ENTRIES);

    // input fields
    logic [7:0]  text_byte;
    logic [9:0]  glyph_slot;
    logic [16:0] slot_ext;
    ugql_pkg::glyph_entry_t wr_entry;

    assign text_byte          = s_tdata[7:0];
    assign glyph_slot         = s_tdata[17:8];
    assign slot_ext           = {7'd0, glyph_slot};
    assign wr_entry.offset_x  = s_tdata[25:18];
    assign wr_entry.offset_y  = s_tdata[33:26];
    assign wr_entry.width     = s_tdata[41:34];
    assign wr_entry.height    = s_tdata[49:42];
    assign wr_entry.advance   = s_tdata[57:50];
    assign wr_entry.atlas_u   = s_tdata[69:58];
    assign wr_entry.atlas_v   = s_tdata[81:70];

    // configuration
    logic [14:0] max_line_width_reg;
    logic [7:0]  line_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_line_width_reg <= ugql_pkg::MAX_LINE_WIDTH_RST;
            line_height_reg    <= ugql_pkg::LINE_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (ugql_pkg::cfg_reg_t'(cfg_addr))
                ugql_pkg::REG_MAX_LINE_WIDTH: max_line_width_reg <= cfg_data;
                ugql_pkg::REG_LINE_HEIGHT:    line_height_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // pipeline handshake
    logic            s1_valid_reg;
    ugql_pkg::op_t   s1_op_reg;
    logic [20:0]     s1_cp_reg;
    logic            out_valid_reg;
    logic [ugql_pkg::OUT_DATA_BITS-1:0] out_data_reg;
    logic            s1_emit;
    logic            out_free;
    logic            s1_move;
    logic            accept;

    assign s1_emit  = s1_valid_reg && (s1_op_reg == ugql_pkg::OP_GLYPH);
    assign out_free = !out_valid_reg || m_tready;
    assign s1_move  = !s1_emit || out_free;
    assign s_tready = s1_move;
    assign accept   = s_tvalid && s_tready;

    // utf8 decode
    logic [20:0]   partial_code_reg;
    logic [20:0]   partial_code_next;
    logic [1:0]    bytes_pending_reg;
    logic [1:0]    bytes_pending_next;
    logic          s0_valid;
    ugql_pkg::op_t s0_op;
    logic [20:0]   s0_cp;
    logic          ram_we;

    always_comb
    begin
        partial_code_next  = partial_code_reg;
        bytes_pending_next = bytes_pending_reg;
        s0_valid           = 1'b0;
        s0_op              = ugql_pkg::OP_GLYPH;
        s0_cp              = partial_code_reg;
        ram_we             = 1'b0;
        case (ugql_pkg::mode_t'(s_tuser))
            ugql_pkg::MODE_TEXT:
            begin
                if (bytes_pending_reg != 2'd0)
                begin
                    partial_code_next  = {partial_code_reg[14:0], text_byte[5:0]};
                    bytes_pending_next = bytes_pending_reg - 2'd1;
                    s0_cp              = partial_code_next;
                    s0_valid           = (bytes_pending_reg == 2'd1);
                end
                else if (text_byte <= ugql_pkg::BYTE_ASCII_MAX)
                begin
                    s0_valid = 1'b1;
                    s0_cp    = {13'd0, text_byte};
                    if (text_byte == ugql_pkg::BYTE_NEWLINE)
                    begin
                        s0_op = ugql_pkg::OP_NEWLINE;
                    end
                end
                else if (text_byte >= ugql_pkg::LEAD2_MIN && text_byte <= ugql_pkg::LEAD2_MAX)
                begin
                    partial_code_next  = {16'd0, text_byte[4:0]};
                    bytes_pending_next = 2'd1;
                end
                else if (text_byte >= ugql_pkg::LEAD3_MIN && text_byte <= ugql_pkg::LEAD3_MAX)
                begin
                    partial_code_next  = {17'd0, text_byte[3:0]};
                    bytes_pending_next = 2'd2;
                end
                else if (text_byte >= ugql_pkg::LEAD4_MIN && text_byte <= ugql_pkg::LEAD4_MAX)
                begin
                    partial_code_next  = {18'd0, text_byte[2:0]};
                    bytes_pending_next = 2'd3;
                end
            end
            ugql_pkg::MODE_GLYPH:
            begin
                ram_we = (slot_ext < ENTRIES_SLOT);
            end
            ugql_pkg::MODE_CLEAR:
            begin
                partial_code_next  = 21'd0;
                bytes_pending_next = 2'd0;
                s0_valid           = 1'b1;
                s0_op              = ugql_pkg::OP_CLEAR;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_code_reg  <= 21'd0;
            bytes_pending_reg <= 2'd0;
            s1_valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                partial_code_reg  <= partial_code_next;
                bytes_pending_reg <= bytes_pending_next;
            end
            if (s1_move)
            begin
                s1_valid_reg <= accept && s0_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg <= s0_op;
            s1_cp_reg <= s0_cp;
        end
    end

    // glyph table
    logic [AW-1:0] rd_addr;
    ugql_pkg::glyph_entry_t rd_entry;

    assign rd_addr = (s0_cp < ENTRIES_CP) ? s0_cp[AW-1:0] : '0;

    ugql_ram #(
        .WIDTH (ugql_pkg::GLYPH_BITS),
        .DEPTH (GLYPH_ENTRIES)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (accept && ram_we),
        .waddr (slot_ext[AW-1:0]),
        .wdata (wr_entry),
        .re    (accept && s0_valid && (s0_op == ugql_pkg::OP_GLYPH)),
        .raddr (rd_addr),
        .rdata (rd_entry)
    );

    // layout
    logic [15:0] pen_x_reg;
    logic [15:0] pen_y_reg;
    logic [QUAD_COUNT_BITS-1:0] quad_count_reg;
    logic [QUAD_COUNT_BITS+1:0] vertex_full;
    logic [17:0] fit_sum;
    logic        wrap;
    logic [15:0] pen_y_line;
    logic [15:0] pen_x_use;
    logic [15:0] pen_y_use;
    logic [15:0] off_x16;
    logic [15:0] off_y16;
    logic [15:0] quad_left;
    logic [15:0] quad_bottom;
    logic [15:0] quad_right;
    logic [15:0] quad_top;
    logic [12:0] tex_u_second;
    logic [12:0] tex_v_second;
    logic [17:0] base_vertex;

    assign off_x16    = {{8{rd_entry.offset_x[7]}}, rd_entry.offset_x};
    assign off_y16    = {{8{rd_entry.offset_y[7]}}, rd_entry.offset_y};
    assign fit_sum    = {{2{pen_x_reg[15]}}, pen_x_reg} + {{2{off_x16[15]}}, off_x16}
                        + {10'd0, rd_entry.width};
    assign wrap       = (max_line_width_reg != 15'd0)
                        && ($signed(fit_sum) >= $signed({3'd0, max_line_width_reg}));
    assign pen_y_line = pen_y_reg - {8'd0, line_height_reg};
    assign pen_x_use  = wrap ? 16'd0 : pen_x_reg;
    assign pen_y_use  = wrap ? pen_y_line : pen_y_reg;
    assign quad_left    = pen_x_use + off_x16;
    assign quad_bottom  = pen_y_use + off_y16;
    assign quad_right   = quad_left + {8'd0, rd_entry.width};
    assign quad_top     = quad_bottom + {8'd0, rd_entry.height};
    assign tex_u_second = {1'b0, rd_entry.atlas_u} + {5'd0, rd_entry.width};
    assign tex_v_second = {1'b0, rd_entry.atlas_v} + {5'd0, rd_entry.height};
    assign vertex_full  = {quad_count_reg, 2'b00};
    assign base_vertex  = 18'(vertex_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg      <= 16'd0;
            pen_y_reg      <= 16'd0;
            quad_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s1_valid_reg && s1_move)
            begin
                case (s1_op_reg)
                    ugql_pkg::OP_GLYPH:
                    begin
                        pen_x_reg      <= pen_x_use + {8'd0, rd_entry.advance};
                        pen_y_reg      <= pen_y_use;
                        quad_count_reg <= quad_count_reg + 1'b1;
                    end
                    ugql_pkg::OP_NEWLINE:
                    begin
                        pen_x_reg <= 16'd0;
                        pen_y_reg <= pen_y_line;
                    end
                    ugql_pkg::OP_CLEAR:
                    begin
                        pen_x_reg      <= 16'd0;
                        pen_y_reg      <= 16'd0;
                        quad_count_reg <= '0;
                    end
                    default: ;
                endcase
            end
            if (s1_emit && s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_emit && s1_move)
        begin
            out_data_reg <= {7'd0, s1_cp_reg, base_vertex, tex_v_second, tex_u_second,
                             rd_entry.atlas_v, rd_entry.atlas_u,
                             quad_top, quad_right, quad_bottom, quad_left};
        end
    end

    assign m_tdata  = out_data_reg;
    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

FILE: hdl/ugql_checker.sv
// port-level checker for the utf8 glyph quad layout block, bound to the top
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_glyph_quad_layout_macros.svh"

module ugql_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               s_tvalid,
    input wire logic                               s_tready,
    input wire logic [ugql_pkg::OUT_DATA_BITS-1:0] m_tdata,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready
);

    // a stalled output beat stays
    `UGQL_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid, "output beat dropped while stalled")

    `UGQL_ASSERT(a_out_stable, clk, rst_n, m_tvalid && !m_tready |=> $stable(m_tdata), "output beat changed while stalled")

    // base vertex counts whole quads
    `UGQL_ASSERT(a_vertex_quad, clk, rst_n, m_tvalid |-> m_tdata[115:114] == 2'b00, "base vertex not a multiple of four")

    // texel corners never fall below the first corner
    `UGQL_ASSERT(a_tex_order, clk, rst_n, m_tvalid |-> m_tdata[100:88] >= {1'b0, m_tdata[75:64]} && m_tdata[113:101] >= {1'b0, m_tdata[87:76]}, "texel corners out of order")

    // nothing shows valid while reset is held
    `UGQL_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !m_tvalid, "output valid during reset")

endmodule

bind utf8_glyph_quad_layout ugql_checker u_ugql_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire

FILE: verif/utf8_glyph_quad_layout_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the utf8 glyph quad layout block
module utf8_glyph_quad_layout_test;
    import ugql_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_CYCLES  = 300;
    localparam int IDLE_PCT      = 24;
    localparam int TABLE_SIZE    = GLYPH_ENTRIES_DEF;

    localparam logic [1:0] MODE_UNUSED    = 2'd3;
    localparam logic [7:0] CONT_MIN       = 8'h80;
    localparam logic [7:0] CONT_MAX       = 8'hbf;
    localparam logic [7:0] STRAY_HIGH_MIN = 8'hf8;
    localparam logic [7:0] STRAY_HIGH_MAX = 8'hff;

    // one output beat, first field in the lowest bits
    typedef struct packed {
        logic [20:0] code_point;
        logic [17:0] base_vertex;
        logic [12:0] tex_v_second;
        logic [12:0] tex_u_second;
        logic [11:0] tex_v_first;
        logic [11:0] tex_u_first;
        logic [15:0] quad_top;
        logic [15:0] quad_right;
        logic [15:0] quad_bottom;
        logic [15:0] quad_left;
    } quad_t;

    logic                      clk      = 1'b0;
    logic                      rst_n    = 1'b0;
    logic [1:0]                s_tuser  = '0;
    logic [IN_DATA_BITS-1:0]   s_tdata  = '0;
    logic                      s_tvalid = 1'b0;
    wire                       s_tready;
    wire  [OUT_DATA_BITS-1:0]  m_tdata;
    wire                       m_tvalid;
    logic                      m_tready = 1'b0;
    logic                      cfg_we   = 1'b0;
    logic [0:0]                cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    // layout state mirrored from the block
    logic [15:0]  pen_x      = '0;
    logic [15:0]  pen_y      = '0;
    logic [15:0]  quad_cnt   = '0;
    logic [20:0]  partial_cp = '0;
    logic [1:0]   bytes_left = '0;
    logic [14:0]  wrap_width = MAX_LINE_WIDTH_RST;
    logic [7:0]   line_ht    = LINE_HEIGHT_RST;
    glyph_entry_t glyph_tab [TABLE_SIZE];
    quad_t        pending_quads [$];

    int  mismatches      = 0;
    int  cycle_count     = 0;
    int  source_idle_pct = IDLE_PCT;
    int  sink_idle_pct   = IDLE_PCT;
    bit  stall_request   = 1'b0;

    utf8_glyph_quad_layout dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic line_feed();
        pen_y = pen_y - line_ht;
        pen_x = '0;
    endtask

    task automatic place_glyph(input logic [20:0] cp);
        glyph_entry_t g;
        int           reach;
        quad_t        q;
        g = (cp < TABLE_SIZE) ? glyph_tab[cp[9:0]] : glyph_tab[0];
        reach = $signed(pen_x) + $signed(g.offset_x) + $signed({1'b0, g.width});
        if (wrap_width != '0 && reach >= int'(wrap_width))
        begin
            line_feed();
        end
        q.quad_left    = pen_x + {{8{g.offset_x[7]}}, g.offset_x};
        q.quad_bottom  = pen_y + {{8{g.offset_y[7]}}, g.offset_y};
        q.quad_right   = q.quad_left + g.width;
        q.quad_top     = q.quad_bottom + g.height;
        q.tex_u_first  = g.atlas_u;
        q.tex_v_first  = g.atlas_v;
        q.tex_u_second = g.atlas_u + g.width;
        q.tex_v_second = g.atlas_v + g.height;
        q.base_vertex  = {quad_cnt, 2'b00};
        q.code_point   = cp;
        pending_quads.push_back(q);
        quad_cnt = quad_cnt + 1'b1;
        pen_x    = pen_x + g.advance;
    endtask

    task automatic layout_step(input logic [1:0] mode, input logic [IN_DATA_BITS-1:0] data);
        logic [7:0] b;
        b = data[7:0];
        case (mode)
            MODE_TEXT:
            begin
                if (bytes_left != '0)
                begin
                    partial_cp = {partial_cp[14:0], b[5:0]};
                    bytes_left = bytes_left - 1'b1;
                    if (bytes_left == '0)
                    begin
                        place_glyph(partial_cp);
                    end
                end
                else if (b <= BYTE_ASCII_MAX)
                begin
                    if (b == BYTE_NEWLINE)
                    begin
                        line_feed();
                    end
                    else
                    begin
                        place_glyph({13'd0, b});
                    end
                end
                else if (b >= LEAD2_MIN && b <= LEAD2_MAX)
                begin
                    partial_cp = {16'd0, b[4:0]};
                    bytes_left = 2'd1;
                end
                else if (b >= LEAD3_MIN && b <= LEAD3_MAX)
                begin
                    partial_cp = {17'd0, b[3:0]};
                    bytes_left = 2'd2;
                end
                else if (b >= LEAD4_MIN && b <= LEAD4_MAX)
                begin
                    partial_cp = {18'd0, b[2:0]};
                    bytes_left = 2'd3;
                end
            end
            MODE_GLYPH:
            begin
                glyph_tab[data[17:8]] = data[81:18];
            end
            MODE_CLEAR:
            begin
                pen_x      = '0;
                pen_y      = '0;
                partial_cp = '0;
                bytes_left = '0;
                quad_cnt   = '0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 40)
        begin
            $display("mismatch on %s: got %0h expected %0h at %0t", what, got, want, $time);
        end
    endtask

    task automatic check_quad(input quad_t got);
        quad_t want;
        if (pending_quads.size() == 0)
        begin
            report_mismatch("quad with none pending", got.code_point, '0);
            return;
        end
        want = pending_quads.pop_front();
        if (got.quad_left !== want.quad_left)
            report_mismatch("quad_left", got.quad_left, want.quad_left);
        if (got.quad_bottom !== want.quad_bottom)
            report_mismatch("quad_bottom", got.quad_bottom, want.quad_bottom);
        if (got.quad_right !== want.quad_right)
            report_mismatch("quad_right", got.quad_right, want.quad_right);
        if (got.quad_top !== want.quad_top)
            report_mismatch("quad_top", got.quad_top, want.quad_top);
        if (got.tex_u_first !== want.tex_u_first)
            report_mismatch("tex_u_first", got.tex_u_first, want.tex_u_first);
        if (got.tex_v_first !== want.tex_v_first)
            report_mismatch("tex_v_first", got.tex_v_first, want.tex_v_first);
        if (got.tex_u_second !== want.tex_u_second)
            report_mismatch("tex_u_second", got.tex_u_second, want.tex_u_second);
        if (got.tex_v_second !== want.tex_v_second)
            report_mismatch("tex_v_second", got.tex_v_second, want.tex_v_second);
        if (got.base_vertex !== want.base_vertex)
            report_mismatch("base_vertex", got.base_vertex, want.base_vertex);
        if (got.code_point !== want.code_point)
            report_mismatch("code_point", got.code_point, want.code_point);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            check_quad(quad_t'(m_tdata[152:0]));
        end
    end

    // output side: random ready, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge clk);
            end
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL utf8_glyph_quad_layout");
        $finish;
    end

    function automatic glyph_entry_t random_glyph();
        return glyph_entry_t'({$urandom, $urandom});
    endfunction

    function automatic logic [IN_DATA_BITS-1:0] random_fields(input logic [7:0] b);
        return {6'd0, random_glyph(), 10'($urandom), b};
    endfunction

    // called and returns at a falling edge
    task automatic send_beat(input logic [1:0] mode, input logic [IN_DATA_BITS-1:0] data);
        while ($urandom_range(99) < source_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        layout_step(mode, data);
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_beat(MODE_TEXT, random_fields(b));
    endtask

    task automatic send_mode(input logic [1:0] mode);
        send_beat(mode, random_fields(8'($urandom)));
    endtask

    task automatic send_glyph(input logic [9:0] slot, input glyph_entry_t g);
        send_beat(MODE_GLYPH, {6'd0, g, slot, 8'($urandom)});
    endtask

    task automatic send_lead(input int nbytes);
        case (nbytes)
            2:       send_byte(8'($urandom_range(LEAD2_MIN, LEAD2_MAX)));
            3:       send_byte(8'($urandom_range(LEAD3_MIN, LEAD3_MAX)));
            default: send_byte(8'($urandom_range(LEAD4_MIN, LEAD4_MAX)));
        endcase
    endtask

    task automatic send_code(input int nbytes);
        if (nbytes == 1)
        begin
            send_byte(8'($urandom_range(0, BYTE_ASCII_MAX)));
        end
        else
        begin
            send_lead(nbytes);
            repeat (nbytes - 1) send_byte(8'($urandom_range(CONT_MIN, CONT_MAX)));
        end
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_quads.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // block must be idle here
    task automatic write_regs(input logic [14:0] width_px, input logic [7:0] height_px);
        cfg_we   <= 1'b1;
        cfg_addr <= REG_MAX_LINE_WIDTH;
        cfg_data <= width_px;
        @(negedge clk);
        cfg_addr <= REG_LINE_HEIGHT;
        cfg_data <= {7'($urandom), height_px};
        @(negedge clk);
        cfg_we <= 1'b0;
        wrap_width = width_px;
        line_ht    = height_px;
        @(negedge clk);
    endtask

    task automatic random_mix(input int count);
        int sent;
        int pick;
        int nbytes;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                nbytes = $urandom_range(99);
                nbytes = (nbytes < 40) ? 1 : (nbytes < 70) ? 2 : (nbytes < 85) ? 3 : 4;
                send_code(nbytes);
            end
            else if (pick < 63)
                send_byte(BYTE_NEWLINE);
            else if (pick < 75)
                send_glyph(10'($urandom), random_glyph());
            else if (pick < 77)
                send_mode(MODE_CLEAR);
            else if (pick < 80)
                send_mode(MODE_UNUSED);
            else if (pick < 88)
            begin
                if ($urandom_range(1))
                    send_byte(8'($urandom_range(CONT_MIN, CONT_MAX)));
                else
                    send_byte(8'($urandom_range(STRAY_HIGH_MIN, STRAY_HIGH_MAX)));
            end
            else
            begin
                // truncated sequence, the next item gets absorbed as continuation
                nbytes = $urandom_range(2, 4);
                send_lead(nbytes);
                repeat ($urandom_range(0, nbytes - 2)) send_byte(8'($urandom));
            end
            sent++;
        end
    endtask

    task automatic config_phase(input logic [14:0] width_px, input logic [7:0] height_px,
                                input int count);
        wait_drain();
        write_regs(width_px, height_px);
        random_mix(count);
    endtask

    task automatic test_glyph_table_load();
        for (int slot = 0; slot < TABLE_SIZE; slot++)
        begin
            send_glyph(10'(slot), random_glyph());
        end
    endtask

    task automatic test_decode_cases();
        glyph_entry_t g;
        g = '{atlas_v: 12'hfff, atlas_u: 12'hfff, advance: 8'hff, height: 8'hff,
              width: 8'hff, offset_y: 8'h7f, offset_x: 8'h80};
        send_glyph(10'h041, g);
        g = '{atlas_v: 12'h000, atlas_u: 12'h000, advance: 8'h00, height: 8'h00,
              width: 8'h00, offset_y: 8'h80, offset_x: 8'h7f};
        send_glyph(10'h042, g);
        send_byte(8'h41);
        send_byte(8'h42);
        send_byte(8'h00);
        send_byte(BYTE_ASCII_MAX);
        send_byte(BYTE_NEWLINE);
        // two-byte code inside the glyph range
        send_byte(8'hc3);
        send_byte(8'ha9);
        // three-byte code beyond the glyph range falls back to entry 0
        send_byte(8'he2);
        send_byte(8'h82);
        send_byte(8'hac);
        // four-byte code
        send_byte(8'hf0);
        send_byte(8'h9f);
        send_byte(8'h98);
        send_byte(8'h80);
        // stray leads
        send_byte(CONT_MIN);
        send_byte(STRAY_HIGH_MAX);
        send_byte(STRAY_HIGH_MIN);
        send_mode(MODE_UNUSED);
        // last glyph entry
        send_byte(8'hcf);
        send_byte(CONT_MAX);
        // continuation taken without checking its top bits
        send_byte(8'hc5);
        send_byte(8'h41);
        send_mode(MODE_CLEAR);
        send_byte(8'h41);
    endtask

    task automatic test_wrap_settings();
        config_phase(15'd1, 8'd1, 120);
        config_phase(15'd32767, 8'd255, 120);
        config_phase(15'd300, 8'd0, 120);
        config_phase(15'd0, 8'd16, 120);
        config_phase(15'd900, 8'd40, 120);
    endtask

    task automatic test_no_idle_burst();
        source_idle_pct = 0;
        sink_idle_pct   = 0;
        random_mix(250);
        source_idle_pct = IDLE_PCT;
        sink_idle_pct   = IDLE_PCT;
    endtask

    task automatic test_output_backpressure();
        stall_request = 1'b1;
        random_mix(100);
        wait_drain();
    endtask

    task automatic test_random_settings();
        repeat (3)
        begin
            if ($urandom_range(1))
                config_phase(15'($urandom), 8'($urandom), 100);
            else
                config_phase(15'($urandom_range(1, 600)), 8'($urandom), 100);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_glyph_table_load();
        test_decode_cases();
        test_wrap_settings();
        test_no_idle_burst();
        test_output_backpressure();
        test_random_settings();
        wait_drain();
        if (mismatches == 0)
        begin
            $display("PASS utf8_glyph_quad_layout");
        end
        else
        begin
            $display("FAIL utf8_glyph_quad_layout");
        end
        $finish;
    end

endmodule
